>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every clock edge outside reset
`define LMPM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check that cond never holds outside reset
`define LMPM_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> rtl/lmpm_pkg.sv
package lmpm_pkg;

   localparam int DeadSlotsDefault = 4;
   localparam int DeadRegs         = 4;
   localparam int IdxW             = 18;
   localparam int CoordW           = 16;
   localparam int DimW             = 9;
   localparam int ColorW           = 8;
   localparam int SlotW            = 16;
   localparam int OutIdxW          = 16;
   localparam int AddrW            = 5;
   localparam int DataW            = 32;
   localparam int RegIdxW          = 3;
   localparam int OrientW          = 3;
   localparam int CountW           = 3;

   localparam logic [1:0] ST_WRITE = 2'd0;
   localparam logic [1:0] ST_SKIP  = 2'd1;
   localparam logic [1:0] ST_OOB   = 2'd2;
   localparam logic [1:0] ST_DEAD  = 2'd3;

   localparam logic [RegIdxW-1:0] REG_WIDTH  = 3'd0;
   localparam logic [RegIdxW-1:0] REG_HEIGHT = 3'd1;
   localparam logic [RegIdxW-1:0] REG_ORIENT = 3'd2;
   localparam logic [RegIdxW-1:0] REG_COUNT  = 3'd3;
   localparam logic [RegIdxW-1:0] REG_DEAD_A = 3'd4;
   localparam logic [RegIdxW-1:0] REG_DEAD_B = 3'd5;
   localparam logic [RegIdxW-1:0] REG_DEAD_C = 3'd6;
   localparam logic [RegIdxW-1:0] REG_DEAD_D = 3'd7;

   typedef struct packed {
      logic [1:0]        status;
      logic [IdxW-1:0]   index;
      logic [ColorW-1:0] red;
      logic [ColorW-1:0] green;
      logic [ColorW-1:0] blue;
   } pix_type;

   typedef struct packed {
      logic [DimW-1:0]    width;
      logic [DimW-1:0]    height;
      logic [OrientW-1:0] orient;
   } geom_type;

endpackage

>>> rtl/lmpm_map.sv
`include "assert_macros.svh"

module lmpm_map (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         valid_in,
   input  logic [lmpm_pkg::CoordW-1:0]  pos_x,
   input  logic [lmpm_pkg::CoordW-1:0]  pos_y,
   input  logic [lmpm_pkg::ColorW-1:0]  red,
   input  logic [lmpm_pkg::ColorW-1:0]  green,
   input  logic [lmpm_pkg::ColorW-1:0]  blue,
   input  logic                         transparent,
   input  lmpm_pkg::geom_type           geom,
   output logic                         valid_ff,
   output lmpm_pkg::pix_type            pix_ff
);
   import lmpm_pkg::*;

   logic            valid_in_c;
   pix_type         pix_in;
   logic            in_x, in_y;
   logic [DimW-1:0] mx, my, mw, mh, fy, fx;
   logic            rev;
   logic [IdxW-1:0] prod;

   always_comb begin
      in_x = !pos_x[CoordW-1] && (pos_x < {{(CoordW-DimW){1'b0}}, geom.width});
      in_y = !pos_y[CoordW-1] && (pos_y < {{(CoordW-DimW){1'b0}}, geom.height});
      if (geom.orient[0]) begin
         mx = pos_y[DimW-1:0];
         my = pos_x[DimW-1:0];
         mw = geom.height;
         mh = geom.width;
      end else begin
         mx = pos_x[DimW-1:0];
         my = pos_y[DimW-1:0];
         mw = geom.width;
         mh = geom.height;
      end
      fy   = geom.orient[1] ? (mh - my - 1'b1) : my;
      rev  = geom.orient[2] ? !fy[0] : fy[0];
      fx   = rev ? (mw - mx - 1'b1) : mx;
      prod = {{(IdxW-DimW){1'b0}}, fy} * {{(IdxW-DimW){1'b0}}, mw};
      pix_in.red   = red;
      pix_in.green = green;
      pix_in.blue  = blue;
      priority if (transparent) begin
         pix_in.status = ST_SKIP;
         pix_in.index  = '0;
      end else if (!(in_x && in_y)) begin
         pix_in.status = ST_OOB;
         pix_in.index  = '0;
      end else begin
         pix_in.status = ST_WRITE;
         pix_in.index  = prod + {{(IdxW-DimW){1'b0}}, fx};
      end
   end

   assign valid_in_c = valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in_c;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pix_ff <= pix_in;
      end
   end

   `LMPM_ASSERT(a_map_oob_zero, clock, reset,
      valid_ff && pix_ff.status != ST_WRITE |-> pix_ff.index == '0,
      "mapped index not cleared for a rejected write")

endmodule

>>> rtl/lmpm_cell.sv
`include "assert_macros.svh"

module lmpm_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        valid_in,
   input  lmpm_pkg::pix_type           pix_in,
   input  logic [lmpm_pkg::SlotW-1:0]  slot,
   input  logic                        active,
   output logic                        valid_ff,
   output lmpm_pkg::pix_type           pix_ff
);
   import lmpm_pkg::*;

   pix_type         pix_in_c;
   logic [IdxW-1:0] slot_w;

   always_comb begin
      slot_w   = {{(IdxW-SlotW){1'b0}}, slot};
      pix_in_c = pix_in;
      if (active && pix_in.status == ST_WRITE) begin
         if (slot_w == pix_in.index) begin
            pix_in_c.status = ST_DEAD;
            pix_in_c.index  = '0;
         end else if (slot_w < pix_in.index) begin
            pix_in_c.index = pix_in.index - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pix_ff <= pix_in_c;
      end
   end

   `LMPM_ASSERT(a_cell_step, clock, reset,
      valid_ff && $past(en) && $past(pix_in.status) == ST_WRITE |->
         pix_ff.status == ST_DEAD || pix_ff.index == $past(pix_in.index) ||
         pix_ff.index == $past(pix_in.index) - 1'b1,
      "dead slot moved the index by more than one")
   `LMPM_ASSERT(a_cell_dead_match, clock, reset,
      valid_ff && $past(en) && pix_ff.status == ST_DEAD &&
         $past(pix_in.status) == ST_WRITE |->
         $past(slot_w) == $past(pix_in.index) && $past(active),
      "pixel marked dead without a matching slot")

endmodule

>>> rtl/led_matrix_pixel_mapper.sv
// Serpentine LED matrix pixel mapper. Each req transaction is one pixel write; each
// rsp transaction carries its status, LED string index and color. The path is a map
// stage (bounds check, orientation, zig-zag, row * width + column with one 9x9
// multiply) followed by a chain of DEAD_SLOTS dead-pixel cells, one register each, so
// a pixel is registered in the map stage and in each cell before rsp_tvalid rises, and
// the block takes one pixel per cycle with rsp_tready high. Configure only while idle.
`include "assert_macros.svh"

module led_matrix_pixel_mapper #(
   parameter int DEAD_SLOTS = lmpm_pkg::DeadSlotsDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // pos_x[15:0], pos_y[31:16], red[39:32], green[47:40], blue[55:48]
   input  logic [55:0]                 req_tdata,
   // transparent[0]
   input  logic                        req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // status[1:0], pixel_index[17:2], red[25:18], green[33:26], blue[41:34], zero[47:42]
   output logic [47:0]                 rsp_tdata,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [lmpm_pkg::AddrW-1:0]  csr_paddr,
   input  logic [lmpm_pkg::DataW-1:0]  csr_pwdata,
   output logic [lmpm_pkg::DataW-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import lmpm_pkg::*;

   logic [DimW-1:0]    width_ff, height_ff;
   logic [OrientW-1:0] orient_ff;
   logic [CountW-1:0]  count_ff;
   logic [SlotW-1:0]   dead_ff [DeadRegs];
   logic               wr_en;
   logic [RegIdxW-1:0] reg_sel;
   geom_type           geom;
   logic               adv;
   logic               valid_s [DEAD_SLOTS+1];
   pix_type            pix_s   [DEAD_SLOTS+1];
   pix_type            last_pix;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[AddrW-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DimW'(16);
         height_ff <= DimW'(16);
         orient_ff <= '0;
         count_ff  <= '0;
         for (int i = 0; i < DeadRegs; i++) begin
            dead_ff[i] <= '0;
         end
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_WIDTH:  width_ff   <= csr_pwdata[DimW-1:0];
            REG_HEIGHT: height_ff  <= csr_pwdata[DimW-1:0];
            REG_ORIENT: orient_ff  <= csr_pwdata[OrientW-1:0];
            REG_COUNT:  count_ff   <= csr_pwdata[CountW-1:0];
            REG_DEAD_A: dead_ff[0] <= csr_pwdata[SlotW-1:0];
            REG_DEAD_B: dead_ff[1] <= csr_pwdata[SlotW-1:0];
            REG_DEAD_C: dead_ff[2] <= csr_pwdata[SlotW-1:0];
            REG_DEAD_D: dead_ff[3] <= csr_pwdata[SlotW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_WIDTH:  csr_prdata = {{(DataW-DimW){1'b0}}, width_ff};
         REG_HEIGHT: csr_prdata = {{(DataW-DimW){1'b0}}, height_ff};
         REG_ORIENT: csr_prdata = {{(DataW-OrientW){1'b0}}, orient_ff};
         REG_COUNT:  csr_prdata = {{(DataW-CountW){1'b0}}, count_ff};
         REG_DEAD_A: csr_prdata = {{(DataW-SlotW){1'b0}}, dead_ff[0]};
         REG_DEAD_B: csr_prdata = {{(DataW-SlotW){1'b0}}, dead_ff[1]};
         REG_DEAD_C: csr_prdata = {{(DataW-SlotW){1'b0}}, dead_ff[2]};
         REG_DEAD_D: csr_prdata = {{(DataW-SlotW){1'b0}}, dead_ff[3]};
         default:    csr_prdata = '0;
      endcase
   end

   assign geom.width  = width_ff;
   assign geom.height = height_ff;
   assign geom.orient = orient_ff;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   lmpm_map u_map (
      .clock       (clock),
      .reset       (reset),
      .en          (adv),
      .valid_in    (req_tvalid),
      .pos_x       (req_tdata[15:0]),
      .pos_y       (req_tdata[31:16]),
      .red         (req_tdata[39:32]),
      .green       (req_tdata[47:40]),
      .blue        (req_tdata[55:48]),
      .transparent (req_tuser),
      .geom        (geom),
      .valid_ff    (valid_s[0]),
      .pix_ff      (pix_s[0])
   );

   for (genvar g = 0; g < DEAD_SLOTS; g++) begin : g_cell
      lmpm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (adv),
         .valid_in (valid_s[g]),
         .pix_in   (pix_s[g]),
         .slot     (dead_ff[g]),
         .active   (count_ff > CountW'(g)),
         .valid_ff (valid_s[g+1]),
         .pix_ff   (pix_s[g+1])
      );
   end

   assign last_pix   = pix_s[DEAD_SLOTS];
   assign rsp_tvalid = valid_s[DEAD_SLOTS];
   assign rsp_tdata  = {6'd0, last_pix.blue, last_pix.green, last_pix.red,
                        last_pix.index[OutIdxW-1:0], last_pix.status};

   `LMPM_ASSERT(a_top_idx_clear, clock, reset,
      rsp_tvalid && last_pix.status != ST_WRITE |-> last_pix.index == '0,
      "index not cleared on a non-write status")
   `LMPM_ASSERT(a_top_hold, clock, reset,
      $past(rsp_tvalid) && !$past(rsp_tready) |-> rsp_tvalid && $stable(rsp_tdata),
      "stalled result lost or changed")
   `LMPM_NEVER(a_top_accept_stall, clock, reset,
      req_tready && rsp_tvalid && !rsp_tready,
      "input taken while the chain is stalled")

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import lmpm_pkg::*;

   localparam int DEAD_SLOTS   = DeadSlotsDefault;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_PERCENT = 8;
   localparam int SETTLE_WAIT  = DEAD_SLOTS + 4;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        transparent;
   } pixel_write_type;

   typedef struct {
      logic [1:0]  status;
      logic [15:0] pixel_index;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } pixel_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [AddrW-1:0] csr_paddr = '0;
   logic [DataW-1:0] csr_pwdata = '0;
   logic [DataW-1:0] csr_prdata;
   logic        csr_pready;

   logic [8:0]  cfg_width = 9'd16;
   logic [8:0]  cfg_height = 9'd16;
   logic [2:0]  cfg_orient = 3'd0;
   logic [2:0]  cfg_count = 3'd0;
   logic [15:0] cfg_dead [4] = '{default: 16'd0};

   pixel_write_type  pending_pixels [$];
   pixel_result_type expected_pixels [$];
   pixel_write_type  drive_item;
   pixel_result_type want;
   pixel_result_type got;

   int  mismatches = 0;
   int  cycle_count = 0;
   bit  req_taken = 1'b0;
   bit  steady_flow = 1'b0;
   int  hold_requests = 0;
   int  hold_served = 0;
   int  hold_left = 0;

   led_matrix_pixel_mapper u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   function automatic pixel_result_type map_pixel(input logic [55:0] data,
                                                  input logic transparent);
      pixel_result_type res;
      int sx;
      int sy;
      int unsigned x;
      int unsigned y;
      int unsigned w;
      int unsigned h;
      int unsigned tmp;
      int unsigned idx;
      int unsigned slots;
      res.red = data[39:32];
      res.green = data[47:40];
      res.blue = data[55:48];
      res.status = ST_WRITE;
      res.pixel_index = '0;
      sx = $signed(data[15:0]);
      sy = $signed(data[31:16]);
      if (transparent) begin
         res.status = ST_SKIP;
      end else if (sx < 0 || sy < 0 || sx >= int'(cfg_width) || sy >= int'(cfg_height)) begin
         res.status = ST_OOB;
      end else begin
         x = sx;
         y = sy;
         w = cfg_width;
         h = cfg_height;
         if (cfg_orient[0]) begin
            tmp = x; x = y; y = tmp;
            tmp = w; w = h; h = tmp;
         end
         if (cfg_orient[1]) y = h - y - 1;
         if (y[0] != cfg_orient[2]) x = w - x - 1;
         idx = y * w + x;
         slots = (cfg_count < DEAD_SLOTS) ? cfg_count : DEAD_SLOTS;
         for (int i = 0; i < slots; i++) begin
            if (cfg_dead[i] == idx) begin
               res.status = ST_DEAD;
               break;
            end
            if (cfg_dead[i] < idx) idx = idx - 1;
         end
         if (res.status == ST_WRITE) res.pixel_index = idx[15:0];
      end
      return res;
   endfunction

   function automatic logic [15:0] boundary_coord(input int dim);
      case ($urandom_range(0, 4))
         0: return 16'hFFFF;
         1: return 16'(dim);
         2: return 16'(dim - 1);
         3: return 16'h7FFF;
         default: return 16'h8000;
      endcase
   endfunction

   function automatic pixel_write_type random_pixel();
      pixel_write_type p;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      p.red = $urandom;
      p.green = $urandom;
      p.blue = $urandom;
      p.transparent = ($urandom_range(0, 99) < 8);
      if (pick < 80 && cfg_width != 0 && cfg_height != 0) begin
         p.pos_x = $urandom_range(0, cfg_width - 1);
         p.pos_y = $urandom_range(0, cfg_height - 1);
      end else if (pick < 90) begin
         p.pos_x = boundary_coord(cfg_width);
         p.pos_y = boundary_coord(cfg_height);
      end else begin
         p.pos_x = $urandom;
         p.pos_y = $urandom;
      end
      return p;
   endfunction

   task automatic queue_pixel(input logic [15:0] x, input logic [15:0] y,
                              input logic [23:0] rgb, input logic transparent);
      pixel_write_type p;
      p.pos_x = x;
      p.pos_y = y;
      p.red = rgb[23:16];
      p.green = rgb[15:8];
      p.blue = rgb[7:0];
      p.transparent = transparent;
      pending_pixels.push_back(p);
   endtask

   task automatic random_pixels(input int count);
      repeat (count) pending_pixels.push_back(random_pixel());
   endtask

   task automatic wait_drain();
      do @(posedge clock);
      while (pending_pixels.size() != 0 || req_tvalid || expected_pixels.size() != 0);
   endtask

   task automatic csr_write(input logic [RegIdxW-1:0] reg_sel, input logic [31:0] value);
      logic [31:0] mask;
      logic [31:0] wdata;
      case (reg_sel)
         REG_WIDTH, REG_HEIGHT: mask = 32'h1FF;
         REG_ORIENT, REG_COUNT: mask = 32'h7;
         default:               mask = 32'hFFFF;
      endcase
      wdata = ($urandom & ~mask) | (value & mask);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {reg_sel, 2'b00};
      csr_pwdata <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      case (reg_sel)
         REG_WIDTH:  cfg_width = wdata[8:0];
         REG_HEIGHT: cfg_height = wdata[8:0];
         REG_ORIENT: cfg_orient = wdata[2:0];
         REG_COUNT:  cfg_count = wdata[2:0];
         default:    cfg_dead[reg_sel - REG_DEAD_A] = wdata[15:0];
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic configure_panel(input int w, input int h, input int orient, input int count,
                                  input logic [15:0] a, input logic [15:0] b,
                                  input logic [15:0] c, input logic [15:0] d);
      csr_write(REG_WIDTH, w);
      csr_write(REG_HEIGHT, h);
      csr_write(REG_ORIENT, orient);
      csr_write(REG_COUNT, count);
      csr_write(REG_DEAD_A, a);
      csr_write(REG_DEAD_B, b);
      csr_write(REG_DEAD_C, c);
      csr_write(REG_DEAD_D, d);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_pixels.size() != 0 &&
             (steady_flow || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            drive_item = pending_pixels.pop_front();
            req_tdata <= {drive_item.blue, drive_item.green, drive_item.red,
                          drive_item.pos_y, drive_item.pos_x};
            req_tuser <= drive_item.transparent;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_served < hold_requests) begin
         hold_served = hold_served + 1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) hold_left = hold_left - 1;
      rsp_tready <= (hold_left == 0) && (steady_flow || $urandom_range(0, 99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tdata[1:0];
            got.pixel_index = rsp_tdata[17:2];
            got.red = rsp_tdata[25:18];
            got.green = rsp_tdata[33:26];
            got.blue = rsp_tdata[41:34];
            if (expected_pixels.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: unexpected rsp transaction status=%0d index=%0d rgb=%h%h%h",
                           $time, got.status, got.pixel_index, got.red, got.green, got.blue);
            end else begin
               want = expected_pixels.pop_front();
               if (got.status !== want.status || got.pixel_index !== want.pixel_index ||
                   got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
                  mismatches = mismatches + 1;
                  if (mismatches <= REPORT_LIMIT)
                     $display("%0t: exp st=%0d idx=%0d rgb=%h%h%h, got st=%0d idx=%0d rgb=%h%h%h",
                              $time, want.status, want.pixel_index, want.red, want.green,
                              want.blue, got.status, got.pixel_index, got.red, got.green,
                              got.blue);
               end
            end
         end
         if (req_tvalid && req_tready) expected_pixels.push_back(map_pixel(req_tdata, req_tuser));
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int unsigned w;
      int unsigned h;
      int unsigned area;
      logic [15:0] dead_pick [4];
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_pixel(16'd0, 16'd0, 24'h000000, 1'b0);
      queue_pixel(16'd15, 16'd0, 24'hFFFFFF, 1'b0);
      queue_pixel(16'd0, 16'd1, 24'h123456, 1'b0);
      queue_pixel(16'd15, 16'd15, 24'hA5A5A5, 1'b0);
      queue_pixel(16'hFFFF, 16'd0, 24'hFFFFFF, 1'b0);
      queue_pixel(16'd0, 16'hFFFF, 24'h000000, 1'b0);
      queue_pixel(16'd16, 16'd0, 24'h5A5A5A, 1'b0);
      queue_pixel(16'd0, 16'd16, 24'h0F0F0F, 1'b0);
      queue_pixel(16'h7FFF, 16'h7FFF, 24'hF0F0F0, 1'b0);
      queue_pixel(16'h8000, 16'h8000, 24'h00FF00, 1'b0);
      queue_pixel(16'h8000, 16'd5, 24'hFF00FF, 1'b1);
      queue_pixel(16'd3, 16'd3, 24'hFFFFFF, 1'b1);
      wait_drain();

      configure_panel(4, 4, 0, 7, 16'd0, 16'd15, 16'd5, 16'd5);
      queue_pixel(16'd0, 16'd0, 24'h112233, 1'b0);
      queue_pixel(16'd3, 16'd3, 24'h445566, 1'b0);
      queue_pixel(16'd1, 16'd1, 24'h778899, 1'b0);
      queue_pixel(16'd2, 16'd1, 24'hAABBCC, 1'b0);
      queue_pixel(16'd3, 16'd0, 24'hDDEEFF, 1'b0);
      queue_pixel(16'd0, 16'd3, 24'h010203, 1'b0);
      random_pixels(30);
      wait_drain();

      configure_panel(1, 1, 7, 1, 16'd0, 16'd0, 16'd0, 16'd0);
      random_pixels(30);
      wait_drain();

      configure_panel(0, 0, 2, 4, 16'd0, 16'd1, 16'd2, 16'd3);
      random_pixels(20);
      wait_drain();

      configure_panel(256, 256, 3, 4, $urandom_range(0, 65535), $urandom_range(0, 255),
                      $urandom_range(0, 65535), 16'd65535);
      hold_requests = hold_requests + 1;
      random_pixels(50);
      wait_drain();
      random_pixels(50);
      wait_drain();

      configure_panel(511, 511, 5, 4, 16'hFFFF, 16'd0, $urandom, $urandom);
      random_pixels(60);
      wait_drain();

      for (int phase = 0; phase < 9; phase++) begin
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 16);
         h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 16);
         area = w * h;
         for (int i = 0; i < 4; i++) begin
            if (area != 0 && $urandom_range(0, 3) != 0)
               dead_pick[i] = $urandom_range(0, (area > 65536 ? 65536 : area) - 1);
            else
               dead_pick[i] = $urandom;
         end
         configure_panel(w, h, $urandom_range(0, 7), $urandom_range(0, 7),
                         dead_pick[0], dead_pick[1], dead_pick[2], dead_pick[3]);
         steady_flow = (phase == 4);
         random_pixels(55);
         wait_drain();
         steady_flow = 1'b0;
      end

      wait_drain();
      repeat (SETTLE_WAIT) @(posedge clock);
      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
